[design/plmb_pkg.sv]
// Shared types and constants of the piecewise-linear membership bank.
// No dependencies; plmb_interp and the core refer to this package.
package plmb_pkg;

  localparam int unsigned FixW = 17;
  localparam logic [FixW-1:0] OneFix = 17'h10000;
  localparam int unsigned DivSteps = 17;

  typedef logic [FixW-1:0] fix_t;

  typedef enum logic [1:0] {
    MODE_CREATE   = 2'd0,
    MODE_ADD      = 2'd1,
    MODE_CLASSIFY = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CRT2,
    ST_INS_CMP,
    ST_INS_WR,
    ST_CLS_START,
    ST_CLS_DIRECT,
    ST_CLS_SCAN,
    ST_CLS_WAIT,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_MUL,
    AR_DIV
  } arith_e;

  typedef struct packed {
    logic start;
    fix_t x;
    fix_t x1;
    fix_t y1;
    fix_t x2;
    fix_t y2;
  } interp_req_t;

  typedef struct packed {
    logic done;
    fix_t level;
  } interp_rsp_t;

endpackage

[design/plmb_ifs.sv]
// Valid/ready channel interfaces of the membership bank: input items and results.
// Depends on nothing but plain logic types.
interface plmb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  class_index;
  logic [16:0] position;
  logic [16:0] level;
  logic [16:0] end_level;

  modport source (output valid, mode, class_index, position, level, end_level, input ready);
  modport sink (input valid, mode, class_index, position, level, end_level, output ready);
endinterface

interface plmb_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] level_out;
  logic [2:0]  class_out;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, level_out, class_out, status, last, input ready);
  modport sink (input valid, level_out, class_out, status, last, output ready);
endinterface

[design/plmb_interp.sv]
// Shared interpolation unit: one multiply, then a restoring divide, one bit a cycle.
// Depends on plmb_pkg.
module plmb_interp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  plmb_pkg::interp_req_t req_i,
  output plmb_pkg::interp_rsp_t rsp_o
);

  plmb_pkg::arith_e st_q, st_d;
  logic [4:0]        cnt_q, cnt_d;
  plmb_pkg::fix_t    y1_q, y2_q, mag_q, xr_q, dx_q, rem_q, quo_q;
  plmb_pkg::fix_t    rem_d, quo_d;
  logic              neg_q, zero_q;
  logic [33:0]       prod;
  logic [17:0]       shifted, diff, sum;
  logic              ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= plmb_pkg::AR_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    prod    = 34'(mag_q) * 34'(xr_q);
    shifted = {rem_q, quo_q[16]};
    diff    = shifted - {1'b0, dx_q};
    ge      = !diff[17];
    rem_d   = ge ? diff[16:0] : shifted[16:0];
    quo_d   = {quo_q[15:0], ge};
    sum     = neg_q ? ({1'b0, y1_q} - {1'b0, quo_d}) : ({1'b0, y1_q} + {1'b0, quo_d});
    st_d    = st_q;
    cnt_d   = cnt_q;
    rsp_o   = '0;
    unique case (st_q)
      plmb_pkg::AR_IDLE: begin
        if (req_i.start) st_d = plmb_pkg::AR_MUL;
      end
      plmb_pkg::AR_MUL: begin
        cnt_d = '0;
        if (zero_q) begin
          rsp_o.done  = 1'b1;
          rsp_o.level = y2_q;
          st_d        = plmb_pkg::AR_IDLE;
        end else begin
          st_d = plmb_pkg::AR_DIV;
        end
      end
      plmb_pkg::AR_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(plmb_pkg::DivSteps - 1)) begin
          rsp_o.done = 1'b1;
          // a negative slope can never pass below zero, clamp anyway
          rsp_o.level = (neg_q && sum[17]) ? '0 : sum[16:0];
          st_d        = plmb_pkg::AR_IDLE;
        end
      end
      default: st_d = plmb_pkg::AR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == plmb_pkg::AR_IDLE && req_i.start) begin
      y1_q   <= req_i.y1;
      y2_q   <= req_i.y2;
      neg_q  <= req_i.y2 < req_i.y1;
      mag_q  <= (req_i.y2 < req_i.y1) ? req_i.y1 - req_i.y2 : req_i.y2 - req_i.y1;
      xr_q   <= req_i.x - req_i.x1;
      dx_q   <= req_i.x2 - req_i.x1;
      zero_q <= req_i.x2 <= req_i.x1;
    end
    if (st_q == plmb_pkg::AR_MUL) begin
      // quotient fits 17 bits, so the upper half is already below the divisor
      rem_q <= prod[33:17];
      quo_q <= prod[16:0];
    end else if (st_q == plmb_pkg::AR_DIV) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

endmodule

[design/piecewise_linear_membership_bank_core.sv]
// Top level of the piecewise-linear membership bank.
// Depends on plmb_pkg, plmb_ifs (channels) and plmb_interp (shared arithmetic).
//
// Usage: in_i carries one command item (create class, add breakpoint, classify).
// out_o carries result items; classify gives one item per created class, in class
// order, with last set on the final one; every other command gives a single item,
// and mode 3 gives none. in_i.ready is high only while the sequencer is idle, so
// one item is worked at a time.
// Sequence: create goes through decode and a second write state to its result; add
// goes through decode, a compare state that shifts each larger breakpoint aside, and
// a write state. Classify, per class, reads one breakpoint directly when the position
// is 0 or at least 1.0; otherwise it scans the breakpoints and, when the position
// falls between breakpoints, waits on the shared multiply/divide unit.
// The breakpoint memory (one write and one registered read a cycle) and the
// bit-serial divider set the pace of these steps.
// Reset: the class count clears; breakpoint tables hold garbage until a class is
// created, which writes its first two entries.
// Stall: a result waits in the output register; the sequencer holds its next
// result until the register frees, and a new item can be taken while the final
// result of the previous one still waits.
module piecewise_linear_membership_bank_core #(
  parameter int unsigned MAX_CLASSES = 8,
  parameter int unsigned MAX_POINTS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  plmb_in_if.sink   in_i,
  plmb_out_if.source out_o
);

  localparam int unsigned CW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned PW  = $clog2(MAX_POINTS);
  localparam int unsigned CCW = $clog2(MAX_CLASSES + 1);
  localparam int unsigned PCW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW  = CW + PW;

  // sequencer state
  plmb_pkg::state_e state_q, state_d;
  logic [CCW-1:0]   cc_q, cc_d;
  logic [PCW-1:0]   pc_q [MAX_CLASSES];
  logic [PCW-1:0]   pc_wdata;
  logic             pc_we;
  logic [CW-1:0]    pc_waddr;
  logic [PCW-1:0]   j_q, j_d, i_q, i_d;
  logic [CW-1:0]    c_q, c_d;

  // latched input item
  plmb_pkg::mode_e  lat_mode_q;
  logic [2:0]       lat_ci_q;
  plmb_pkg::fix_t   lat_pos_q, lat_lvl_q, lat_end_q;

  // breakpoint memory: {position, level}
  logic [33:0]      mem [2**AW];
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [33:0]      wdata, rdata_q, prev_q, prev_d;

  // pending result and output register
  plmb_pkg::fix_t   res_lvl_q, res_lvl_d;
  logic [2:0]       res_cls_q, res_cls_d;
  plmb_pkg::status_e res_sts_q, res_sts_d;
  logic             res_last_q, res_last_d;
  logic             ov_q, ov_d, out_load, slot_free;
  plmb_pkg::fix_t   o_lvl_q;
  logic [2:0]       o_cls_q;
  plmb_pkg::status_e o_sts_q;
  logic             o_last_q;

  plmb_pkg::interp_req_t req;
  plmb_pkg::interp_rsp_t rsp;

  logic [CW-1:0]    ci;
  logic [PCW-1:0]   n_add, n_cls;
  plmb_pkg::fix_t   rpos, rlvl;
  logic             in_acc;

  plmb_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_i.ready      = (state_q == plmb_pkg::ST_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign out_o.valid     = ov_q;
  assign out_o.level_out = o_lvl_q;
  assign out_o.class_out = o_cls_q;
  assign out_o.status    = o_sts_q;
  assign out_o.last      = o_last_q;

  assign slot_free = !ov_q || out_o.ready;
  assign ci        = CW'(lat_ci_q);
  assign n_add     = pc_q[ci];
  assign n_cls     = pc_q[c_q];
  assign rpos      = rdata_q[33:17];
  assign rlvl      = rdata_q[16:0];

  always_comb begin
    state_d    = state_q;
    cc_d       = cc_q;
    j_d        = j_q;
    i_d        = i_q;
    c_d        = c_q;
    prev_d     = prev_q;
    res_lvl_d  = res_lvl_q;
    res_cls_d  = res_cls_q;
    res_sts_d  = res_sts_q;
    res_last_d = res_last_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = '0;
    pc_we      = 1'b0;
    pc_waddr   = ci;
    pc_wdata   = '0;
    out_load   = 1'b0;
    req.start  = 1'b0;
    req.x      = lat_pos_q;
    req.x1     = prev_q[33:17];
    req.y1     = prev_q[16:0];
    req.x2     = rpos;
    req.y2     = rlvl;

    unique case (state_q)
      plmb_pkg::ST_IDLE: begin
        if (in_acc) state_d = plmb_pkg::ST_DECODE;
      end

      plmb_pkg::ST_DECODE: begin
        res_lvl_d  = '0;
        res_cls_d  = lat_ci_q;
        res_sts_d  = plmb_pkg::STS_OK;
        res_last_d = 1'b1;
        unique case (lat_mode_q)
          plmb_pkg::MODE_CREATE: begin
            if (cc_q == CCW'(MAX_CLASSES)) begin
              res_cls_d = '0;
              res_sts_d = plmb_pkg::STS_FULL;
              state_d   = plmb_pkg::ST_EMIT;
            end else begin
              we      = 1'b1;
              waddr   = {CW'(cc_q), PW'(0)};
              wdata   = {17'd0, lat_lvl_q};
              state_d = plmb_pkg::ST_CRT2;
            end
          end
          plmb_pkg::MODE_ADD: begin
            if (5'(lat_ci_q) >= 5'(cc_q)) begin
              res_sts_d = plmb_pkg::STS_BAD_INDEX;
              state_d   = plmb_pkg::ST_EMIT;
            end else if (n_add == PCW'(MAX_POINTS)) begin
              res_sts_d = plmb_pkg::STS_FULL;
              state_d   = plmb_pkg::ST_EMIT;
            end else begin
              j_d   = n_add;
              raddr = {ci, PW'(n_add - PCW'(1))};
              // empty table cannot occur after create, handle it plainly
              state_d = (n_add == '0) ? plmb_pkg::ST_INS_WR : plmb_pkg::ST_INS_CMP;
            end
          end
          plmb_pkg::MODE_CLASSIFY: begin
            if (cc_q == '0) begin
              res_cls_d = '0;
              res_sts_d = plmb_pkg::STS_EMPTY;
              state_d   = plmb_pkg::ST_EMIT;
            end else begin
              c_d     = '0;
              state_d = plmb_pkg::ST_CLS_START;
            end
          end
          plmb_pkg::MODE_NONE: state_d = plmb_pkg::ST_IDLE;
          default: state_d = plmb_pkg::ST_IDLE;
        endcase
      end

      plmb_pkg::ST_CRT2: begin
        we        = 1'b1;
        waddr     = {CW'(cc_q), PW'(1)};
        wdata     = {plmb_pkg::OneFix, lat_end_q};
        pc_we     = 1'b1;
        pc_waddr  = CW'(cc_q);
        pc_wdata  = PCW'(2);
        cc_d      = cc_q + CCW'(1);
        res_cls_d = 3'(cc_q);
        state_d   = plmb_pkg::ST_EMIT;
      end

      plmb_pkg::ST_INS_CMP: begin
        // rdata_q holds entry j-1; move it one place up while it sorts after
        if (rpos > lat_pos_q) begin
          we    = 1'b1;
          waddr = {ci, j_q[PW-1:0]};
          wdata = rdata_q;
          j_d   = j_q - PCW'(1);
          if (j_q == PCW'(1)) begin
            state_d = plmb_pkg::ST_INS_WR;
          end else begin
            raddr = {ci, PW'(j_q - PCW'(2))};
          end
        end else begin
          state_d = plmb_pkg::ST_INS_WR;
        end
      end

      plmb_pkg::ST_INS_WR: begin
        we       = 1'b1;
        waddr    = {ci, j_q[PW-1:0]};
        wdata    = {lat_pos_q, lat_lvl_q};
        pc_we    = 1'b1;
        pc_wdata = n_add + PCW'(1);
        state_d  = plmb_pkg::ST_EMIT;
      end

      plmb_pkg::ST_CLS_START: begin
        res_cls_d  = 3'(c_q);
        res_sts_d  = plmb_pkg::STS_OK;
        res_last_d = (CCW'(c_q) + CCW'(1)) == cc_q;
        i_d        = '0;
        if (n_cls == '0) begin
          res_lvl_d = '0;
          state_d   = plmb_pkg::ST_EMIT;
        end else if (lat_pos_q == '0) begin
          raddr   = {c_q, PW'(0)};
          state_d = plmb_pkg::ST_CLS_DIRECT;
        end else if (lat_pos_q >= plmb_pkg::OneFix) begin
          raddr   = {c_q, PW'(n_cls - PCW'(1))};
          state_d = plmb_pkg::ST_CLS_DIRECT;
        end else begin
          raddr   = {c_q, PW'(0)};
          state_d = plmb_pkg::ST_CLS_SCAN;
        end
      end

      plmb_pkg::ST_CLS_DIRECT: begin
        res_lvl_d = rlvl;
        state_d   = plmb_pkg::ST_EMIT;
      end

      plmb_pkg::ST_CLS_SCAN: begin
        if (rpos >= lat_pos_q) begin
          if (i_q == '0) begin
            res_lvl_d = rlvl;
            state_d   = plmb_pkg::ST_EMIT;
          end else begin
            req.start = 1'b1;
            state_d   = plmb_pkg::ST_CLS_WAIT;
          end
        end else begin
          prev_d = rdata_q;
          i_d    = i_q + PCW'(1);
          if (i_q + PCW'(1) == n_cls) begin
            // no bracketing breakpoint: hold the last level
            res_lvl_d = rlvl;
            state_d   = plmb_pkg::ST_EMIT;
          end else begin
            raddr = {c_q, PW'(i_q + PCW'(1))};
          end
        end
      end

      plmb_pkg::ST_CLS_WAIT: begin
        if (rsp.done) begin
          res_lvl_d = rsp.level;
          state_d   = plmb_pkg::ST_EMIT;
        end
      end

      plmb_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (res_last_q) begin
            state_d = plmb_pkg::ST_IDLE;
          end else begin
            c_d     = c_q + CW'(1);
            state_d = plmb_pkg::ST_CLS_START;
          end
        end
      end

      default: state_d = plmb_pkg::ST_IDLE;
    endcase

    ov_d = (ov_q && !out_o.ready) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plmb_pkg::ST_IDLE;
      cc_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cc_q    <= cc_d;
      ov_q    <= ov_d;
    end
  end

  // payload and scratch registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lat_mode_q <= plmb_pkg::mode_e'(in_i.mode);
      lat_ci_q   <= in_i.class_index;
      lat_pos_q  <= in_i.position;
      lat_lvl_q  <= in_i.level;
      lat_end_q  <= in_i.end_level;
    end
    j_q        <= j_d;
    i_q        <= i_d;
    c_q        <= c_d;
    prev_q     <= prev_d;
    res_lvl_q  <= res_lvl_d;
    res_cls_q  <= res_cls_d;
    res_sts_q  <= res_sts_d;
    res_last_q <= res_last_d;
    if (pc_we) pc_q[pc_waddr] <= pc_wdata;
    if (out_load) begin
      o_lvl_q  <= res_lvl_q;
      o_cls_q  <= res_cls_q;
      o_sts_q  <= res_sts_q;
      o_last_q <= res_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

endmodule

[test/tb_top.sv]
// Testbench of the piecewise-linear membership bank: directed and random commands
// with a scoreboard that predicts every result. Depends on plmb_pkg, plmb_ifs and the core.
module tb_top;

  typedef struct packed {
    plmb_pkg::fix_t    level_out;
    logic [2:0]        class_out;
    plmb_pkg::status_e status;
    logic              last;
  } result_t;

  // Predictor of the class bank; holds its own copy of the tables.
  class membership_scoreboard;
    int unsigned    n_classes;
    int unsigned    n_points[8];
    plmb_pkg::fix_t bp_pos[8][16];
    plmb_pkg::fix_t bp_lvl[8][16];
    result_t        pending[$];
    int             errors;

    function new();
      n_classes = 0;
      errors = 0;
    endfunction

    function void push(plmb_pkg::fix_t lv, int unsigned cl, plmb_pkg::status_e st, bit lst);
      result_t r;
      r.level_out = lv;
      r.class_out = cl[2:0];
      r.status = st;
      r.last = lst;
      pending.insert(pending.size(), r);
    endfunction

    function plmb_pkg::fix_t interpolate(int unsigned c, plmb_pkg::fix_t x);
      int unsigned n;
      int unsigned i;
      longint x1, y1, x2, y2, v;
      n = n_points[c];
      if (x == 0) return bp_lvl[c][0];
      if (x >= plmb_pkg::OneFix) return bp_lvl[c][n-1];
      for (i = 0; i < n; i++) if (bp_pos[c][i] >= x) break;
      if (i >= n) return bp_lvl[c][n-1];
      if (i == 0) return bp_lvl[c][0];
      x1 = bp_pos[c][i-1]; y1 = bp_lvl[c][i-1];
      x2 = bp_pos[c][i];   y2 = bp_lvl[c][i];
      if (x2 - x1 <= 0) return plmb_pkg::fix_t'(y2);
      v = y1 + ((y2 - y1) * (longint'(x) - x1)) / (x2 - x1);
      if (v < 0) v = 0;
      return plmb_pkg::fix_t'(v);
    endfunction

    function void note_command(plmb_pkg::mode_e m, logic [2:0] ci, plmb_pkg::fix_t pos,
                               plmb_pkg::fix_t lv, plmb_pkg::fix_t endl);
      int unsigned j;
      case (m)
        plmb_pkg::MODE_CREATE: begin
          if (n_classes >= 8) begin
            push('0, 0, plmb_pkg::STS_FULL, 1);
          end else begin
            bp_pos[n_classes][0] = '0;
            bp_lvl[n_classes][0] = lv;
            bp_pos[n_classes][1] = plmb_pkg::OneFix;
            bp_lvl[n_classes][1] = endl;
            n_points[n_classes] = 2;
            push('0, n_classes, plmb_pkg::STS_OK, 1);
            n_classes++;
          end
        end
        plmb_pkg::MODE_ADD: begin
          if (ci >= n_classes) begin
            push('0, ci, plmb_pkg::STS_BAD_INDEX, 1);
          end else if (n_points[ci] >= 16) begin
            push('0, ci, plmb_pkg::STS_FULL, 1);
          end else begin
            // Shift larger positions up; equal positions stay in front.
            j = n_points[ci];
            while (j > 0 && bp_pos[ci][j-1] > pos) begin
              bp_pos[ci][j] = bp_pos[ci][j-1];
              bp_lvl[ci][j] = bp_lvl[ci][j-1];
              j--;
            end
            bp_pos[ci][j] = pos;
            bp_lvl[ci][j] = lv;
            n_points[ci]++;
            push('0, ci, plmb_pkg::STS_OK, 1);
          end
        end
        plmb_pkg::MODE_CLASSIFY: begin
          if (n_classes == 0) push('0, 0, plmb_pkg::STS_EMPTY, 1);
          else for (int c = 0; c < n_classes; c++)
            push(interpolate(c, pos), c, plmb_pkg::STS_OK, c + 1 == n_classes);
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.level_out !== want.level_out)
        $display("%0t: level_out expected %0d actual %0d", $time, want.level_out,
                 got.level_out);
      if (got.class_out !== want.class_out)
        $display("%0t: class_out expected %0d actual %0d", $time, want.class_out,
                 got.class_out);
      if (got.status !== want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got.last !== want.last)
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  plmb_in_if  cmd_ch();
  plmb_out_if res_ch();

  membership_scoreboard sb = new();
  bit  calm = 1'b0;      // no idling in the closing stretch
  longint cycles = 0;

  piecewise_linear_membership_bank_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(cmd_ch.sink), .out_o(res_ch.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sample results at the rising edge and check them.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready)
      sb.check_result({res_ch.level_out, res_ch.class_out,
                       plmb_pkg::status_e'(res_ch.status), res_ch.last});
  end

  // Receiver stalls in random bursts; drive ready on the falling edge.
  initial begin
    int burst;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 6);
        res_ch.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Cycle limit: stop with FAIL if the run does not finish in time.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 800000) begin
      $display("FAIL piecewise_linear_membership_bank_core");
      $finish;
    end
  end

  // Send one command item; hold it until the handshake completes.
  task automatic send(plmb_pkg::mode_e m, logic [2:0] ci, plmb_pkg::fix_t pos,
                      plmb_pkg::fix_t lv, plmb_pkg::fix_t endl);
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= m;
    cmd_ch.class_index <= ci;
    cmd_ch.position <= pos;
    cmd_ch.level <= lv;
    cmd_ch.end_level <= endl;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_command(m, ci, pos, lv, endl);
    @(negedge clk_i);
  endtask

  function automatic plmb_pkg::fix_t rand_fix();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return plmb_pkg::OneFix;
      2: return 17'h1FFFF;
      3: return plmb_pkg::fix_t'($urandom_range(1, 65535));
      4: return plmb_pkg::fix_t'($urandom);
      default: return plmb_pkg::fix_t'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int pick;
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = plmb_pkg::MODE_NONE;
    cmd_ch.class_index = '0;
    cmd_ch.position = '0;
    cmd_ch.level = '0;
    cmd_ch.end_level = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty bank, bad index, extremes, equal positions, ignored mode.
    send(plmb_pkg::MODE_CLASSIFY, 0, 17'd100, 0, 0);
    send(plmb_pkg::MODE_ADD, 0, 17'd5, 17'd5, 0);
    send(plmb_pkg::MODE_NONE, 3'h7, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send(plmb_pkg::MODE_CREATE, 0, 0, 17'd0, plmb_pkg::OneFix);
    send(plmb_pkg::MODE_CREATE, 0, 0, plmb_pkg::OneFix, 17'd0);
    send(plmb_pkg::MODE_CLASSIFY, 0, 17'd0, 0, 0);
    send(plmb_pkg::MODE_CLASSIFY, 0, 17'd32768, 0, 0);
    send(plmb_pkg::MODE_CLASSIFY, 0, plmb_pkg::OneFix, 0, 0);
    send(plmb_pkg::MODE_CLASSIFY, 0, 17'h1FFFF, 0, 0);
    send(plmb_pkg::MODE_ADD, 1, 17'd30000, 17'd1000, 0);
    send(plmb_pkg::MODE_ADD, 1, 17'd30000, 17'd60000, 0);
    send(plmb_pkg::MODE_ADD, 1, 17'h1FFFF, 17'h1FFFF, 0);
    send(plmb_pkg::MODE_ADD, 1, 17'd0, 17'd777, 0);
    send(plmb_pkg::MODE_ADD, 3'h7, 17'd1, 17'd1, 0);
    send(plmb_pkg::MODE_CLASSIFY, 0, 17'd30000, 0, 0);
    send(plmb_pkg::MODE_CLASSIFY, 0, 17'd30001, 0, 0);
    send(plmb_pkg::MODE_CLASSIFY, 0, 17'd1, 0, 0);
    send(plmb_pkg::MODE_CLASSIFY, 0, 17'd65535, 0, 0);
    for (int k = 0; k < 14; k++)
      send(plmb_pkg::MODE_ADD, 0, plmb_pkg::fix_t'($urandom), rand_fix(), 0);

    // Random: mostly valid adds and classifies over the created classes.
    for (int k = 0; k < 188; k++) begin
      if (k == 160) calm = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 2)
        send(plmb_pkg::MODE_CREATE, 3'($urandom), rand_fix(), rand_fix(), rand_fix());
      else if (pick < 11)
        send(plmb_pkg::MODE_ADD, (pick == 10) ? 3'($urandom) :
             3'($urandom_range(0, sb.n_classes - 1)), rand_fix(), rand_fix(), rand_fix());
      else if (pick < 19)
        send(plmb_pkg::MODE_CLASSIFY, 3'($urandom), rand_fix(), rand_fix(), rand_fix());
      else
        send(plmb_pkg::MODE_NONE, 3'($urandom), rand_fix(), rand_fix(), rand_fix());
    end
    cmd_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS piecewise_linear_membership_bank_core");
    end else begin
      $display("FAIL piecewise_linear_membership_bank_core");
    end
    $finish;
  end
endmodule

[filelist.f]
design/plmb_pkg.sv
design/plmb_ifs.sv
design/plmb_interp.sv
design/piecewise_linear_membership_bank_core.sv
test/tb_top.sv
